FILE: rtl/apnd_pkg.sv
package apnd_pkg;

   // Default capacity of the point store
   localparam int MAX_POINTS_DEF = 64;

   // Coordinate, squared distance and root widths
   localparam int COORD_W = 16;
   localparam int SQ_W    = 34;
   localparam int DIST_W  = 17;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              none_found;
      logic              overflowed;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   // Pair presented to the distance unit
   typedef struct packed {
      logic      valid;
      logic      last;
      point_type pa;
      point_type pb;
   } dist_in_type;

   // Squared distance leaving the distance unit
   typedef struct packed {
      logic            valid;
      logic            last;
      logic            same;
      logic [SQ_W-1:0] sq;
   } dist_out_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_LATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT
   } state_type;

endpackage

FILE: rtl/all_pairs_nearest_distance_core.sv
// Loading: one point per cycle, start taken whenever busy is low.
// Computing: each result comes from a one-pair-per-cycle scan of the point memory
// read port, followed by a bit-serial square root that is skipped when no
// differing point exists.
// Results leave on a one-cycle rsp_valid strobe; the receiver cannot stall.
// Synchronous reset empties the point set and clears the overflow flag.
module all_pairs_nearest_distance_core #(
   parameter int MAX_POINTS = apnd_pkg::MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  apnd_pkg::req_type req_data,
   output logic              rsp_valid,
   output apnd_pkg::rsp_type rsp_data
);
   import apnd_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_POINTS);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   point_type         pi_ff, pi_in;
   logic              found_ff, found_in;
   logic [SQ_W-1:0]   best_ff, best_in;
   logic              scan_vld_ff, scan_vld_in;
   logic              scan_last_ff, scan_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   point_type         point_mem_ff [MAX_POINTS];
   point_type         rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   point_type         wr_point;

   logic              accept;
   logic [CNT_W-1:0]  last_idx;
   logic              i_last, j_last;
   logic              upd;
   logic              found_nx;
   logic [SQ_W-1:0]   best_nx;
   logic              emit;
   logic              emit_none;

   dist_in_type       din;
   dist_out_type      dout;
   logic              root_start;
   logic              root_done;
   logic [DIST_W-1:0] root;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_LOAD);
   assign last_idx = count_ff - CNT_W'(1);
   assign i_last   = (CNT_W'(i_ff) == last_idx);
   assign j_last   = (CNT_W'(j_ff) == last_idx);

   // Point memory: one write port for loading, one registered read port
   assign wr_en          = accept && (count_ff < CAP);
   assign wr_point.x     = req_data.point_x;
   assign wr_point.y     = req_data.point_y;
   assign wr_point.z     = req_data.point_z;
   assign rd_addr        = (state_ff == ST_SCAN) ? j_ff : i_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem_ff[count_ff[IDX_W-1:0]] <= wr_point;
      end
      rd_data_ff <= point_mem_ff[rd_addr];
   end

   // Pair pipeline: current point against each scanned point
   assign din.valid = scan_vld_ff;
   assign din.last  = scan_last_ff;
   assign din.pa    = pi_ff;
   assign din.pb    = rd_data_ff;

   apnd_dist_unit u_dist (
      .clock (clock),
      .reset (reset),
      .din   (din),
      .dout  (dout)
   );

   apnd_isqrt u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .root_start (root_start),
      .radicand   (best_nx),
      .root_done  (root_done),
      .root       (root)
   );

   // Running minimum over differing points
   assign upd      = dout.valid && !dout.same && (!found_ff || (dout.sq < best_ff));
   assign best_nx  = upd ? dout.sq : best_ff;
   assign found_nx = found_ff || (dout.valid && !dout.same);

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pi_in        = pi_ff;
      found_in     = found_nx;
      best_in      = best_nx;
      scan_vld_in  = 1'b0;
      scan_last_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      root_start   = 1'b0;
      emit         = 1'b0;
      emit_none    = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_ff < CAP) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_point) begin
                  i_in     = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            pi_in    = rd_data_ff;
            found_in = 1'b0;
            j_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            scan_vld_in  = 1'b1;
            scan_last_in = j_last;
            j_in         = j_ff + IDX_W'(1);
            if (j_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dout.valid && dout.last) begin
               if (found_nx) begin
                  root_start = 1'b1;
                  state_in   = ST_ROOT;
               end else begin
                  emit      = 1'b1;
                  emit_none = 1'b1;
               end
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               emit = 1'b1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      // Drive one result, then move to the next point or close the set
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.distance    = emit_none ? '0 : root;
         rsp_in.none_found  = emit_none;
         rsp_in.overflowed  = ovf_ff;
         rsp_in.last_result = i_last;
         if (i_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
            state_in = ST_LOAD;
         end else begin
            i_in     = i_ff + IDX_W'(1);
            state_in = ST_FETCH;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      pi_ff        <= pi_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      scan_last_ff <= scan_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/apnd_dist_unit.sv
module apnd_dist_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  apnd_pkg::dist_in_type din,
   output apnd_pkg::dist_out_type dout
);
   import apnd_pkg::*;

   // Stage 1: absolute axis differences and identity check
   logic                s1_vld_ff, s1_last_ff, s1_same_ff;
   logic [COORD_W-1:0]  s1_dx_ff, s1_dy_ff, s1_dz_ff;
   // Stage 2: axis squares
   logic                s2_vld_ff, s2_last_ff, s2_same_ff;
   logic [2*COORD_W-1:0] s2_qx_ff, s2_qy_ff, s2_qz_ff;
   // Stage 3: sum
   logic                s3_vld_ff, s3_last_ff, s3_same_ff;
   logic [SQ_W-1:0]     s3_sq_ff;

   function automatic logic [COORD_W-1:0] abs_diff(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b
   );
      logic signed [COORD_W:0] d;
      logic signed [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? -d : d;
      return m[COORD_W-1:0];
   endfunction

   // Advance valid tags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= din.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      s1_last_ff <= din.last;
      s1_same_ff <= (din.pa == din.pb);
      s1_dx_ff   <= abs_diff(din.pa.x, din.pb.x);
      s1_dy_ff   <= abs_diff(din.pa.y, din.pb.y);
      s1_dz_ff   <= abs_diff(din.pa.z, din.pb.z);

      s2_last_ff <= s1_last_ff;
      s2_same_ff <= s1_same_ff;
      s2_qx_ff   <= s1_dx_ff * s1_dx_ff;
      s2_qy_ff   <= s1_dy_ff * s1_dy_ff;
      s2_qz_ff   <= s1_dz_ff * s1_dz_ff;

      s3_last_ff <= s2_last_ff;
      s3_same_ff <= s2_same_ff;
      s3_sq_ff   <= SQ_W'(s2_qx_ff) + SQ_W'(s2_qy_ff) + SQ_W'(s2_qz_ff);
   end

   assign dout.valid = s3_vld_ff;
   assign dout.last  = s3_last_ff;
   assign dout.same  = s3_same_ff;
   assign dout.sq    = s3_sq_ff;

endmodule

FILE: rtl/apnd_isqrt.sv
module apnd_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          root_start,
   input  logic [apnd_pkg::SQ_W-1:0]     radicand,
   output logic                          root_done,
   output logic [apnd_pkg::DIST_W-1:0]   root
);
   import apnd_pkg::*;

   localparam int REM_W = DIST_W + 1;
   localparam int CNT_W = $clog2(DIST_W);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIST_W-1:0] root_ff, root_in;

   logic [REM_W+1:0]  rem_shift;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  rem_diff;

   // One result bit per cycle, two radicand bits consumed per step
   always_comb begin
      rem_shift = {rem_ff, rad_ff[SQ_W-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      rem_diff  = rem_shift - trial;
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (root_start) begin
         run_in  = 1'b1;
         cnt_in  = CNT_W'(DIST_W - 1);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (run_ff) begin
         rad_in = {rad_ff[SQ_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_diff[REM_W-1:0];
            root_in = {root_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[REM_W-1:0];
            root_in = {root_ff[DIST_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Hold datapath
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root_done = done_ff;
   assign root      = root_ff;

endmodule
